@@ hw/rtl/banded_dtw_frame_aligner_core_assert.svh @@
// ----------------------------------------------------------------------------
// banded dtw frame aligner assertion macros
// shared immediate-style wrappers for concurrent checks
// ----------------------------------------------------------------------------
`ifndef BANDED_DTW_FRAME_ALIGNER_CORE_ASSERT_SVH
`define BANDED_DTW_FRAME_ALIGNER_CORE_ASSERT_SVH

// same-cycle implication
`define BDFA_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BDFA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bdfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bdfa_pkg
// types, codes, log2 fraction table and fixed point helpers of the aligner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdfa_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CELL_RD,
      ST_CELL_TERM,
      ST_CELL_MUL,
      ST_CELL_SUM,
      ST_FILL_WR,
      ST_TRACE_WR,
      ST_DIV,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_FAIL_OUT
   } state_type;

   localparam logic [1:0] MODE_LEAD  = 2'd0;
   localparam logic [1:0] MODE_DUB   = 2'd1;
   localparam logic [1:0] MODE_ALIGN = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_PATH = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   localparam logic [1:0] DIR_DIAG = 2'd1;
   localparam logic [1:0] DIR_UP   = 2'd2;
   localparam logic [1:0] DIR_LEFT = 2'd3;

   localparam logic [2:0] REG_BAND     = 3'd0;
   localparam logic [2:0] REG_PENALTY  = 3'd1;
   localparam logic [2:0] REG_W_ONSET  = 3'd2;
   localparam logic [2:0] REG_W_PITCH  = 3'd3;
   localparam logic [2:0] REG_W_VOICE  = 3'd4;

   localparam logic [15:0] ONE_Q15  = 16'd32768;
   localparam logic [23:0] COST_MAX = 24'hFFFFFF;

   localparam logic [14:0] LOG2_FRAC [32] = '{
      15'd0,     15'd1455,  15'd2866,  15'd4236,  15'd5568,  15'd6863,  15'd8124,  15'd9352,
      15'd10549, 15'd11716, 15'd12855, 15'd13968, 15'd15055, 15'd16117, 15'd17156, 15'd18173,
      15'd19168, 15'd20143, 15'd21098, 15'd22034, 15'd22952, 15'd23853, 15'd24736, 15'd25604,
      15'd26455, 15'd27292, 15'd28114, 15'd28922, 15'd29717, 15'd30498, 15'd31267, 15'd32024};

   // leading-one position in the integer part, table fraction below it
   function automatic logic [18:0] log2_q15(input logic [15:0] p);
      logic [3:0]  pos;
      logic [15:0] norm;
      pos = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (p[i]) pos = 4'(i);
      end
      norm = p << (4'd15 - pos);
      return {pos, LOG2_FRAC[norm[14:10]]};
   endfunction

   function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [23:0] b);
      logic [24:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[24] ? COST_MAX : s[23:0];
   endfunction

   function automatic logic [15:0] confidence(input logic [23:0] c);
      return (c > 24'(ONE_Q15)) ? 16'd0 : 16'(24'(ONE_Q15) - c);
   endfunction

endpackage

@@ hw/rtl/banded_dtw_frame_aligner_core.sv @@
// ----------------------------------------------------------------------------
// banded_dtw_frame_aligner_core
// loads lead and dub frames, runs banded dtw, traces back and streams the path
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid/req_tready   | tuser mode, tdata onset/voiced/pitch
//  rsp     | out | rsp_tvalid/rsp_tready   | tuser status, tdata point, tlast
//  csr     | in  | csr_we                  | csr_addr register index, csr_wdata
//
//  frame loads are taken back to back while idle
//  an align word holds off the input through each in-band cell (read, terms,
//  three weight multiplies one per cycle, sum, write), each path point in the same
//  steps with a trace write, the serial mean divider and each result (read, offer);
//  a no-path result is offered directly; results stall on rsp_tready; reset is synchronous,
//  no memory clearing pass, cells outside the band are recognized from their row and column
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module banded_dtw_frame_aligner_core #(
   parameter int MAX_FRAMES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // onset[15:0], voiced[16], pitch[32:17], zero pad
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // dub[4:0], lead[9:5], point conf[25:10], overall[41:26]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import bdfa_pkg::*;

   localparam int AW       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW       = $clog2(MAX_FRAMES + 1);
   localparam int PATH_MAX = 2 * MAX_FRAMES - 1;
   localparam int PW       = $clog2(PATH_MAX + 1);
   localparam int CD       = 1 << (2 * AW);
   localparam int FW       = 33;
   localparam int EW       = 2 * AW + 16;

   // configuration
   logic [4:0]  band_ff;
   logic [15:0] penalty_ff, w_onset_ff, w_pitch_ff, w_voice_ff;

   // control
   state_type   state_ff, state_in;
   logic [CW-1:0] lead_cnt_ff, dub_cnt_ff;
   logic        overflow_ff;
   logic        tracing_ff;
   logic [AW-1:0] r_ff, c_ff, hi_ff;
   logic [PW-1:0] n_ff, k_ff;
   logic [1:0]  mul_cnt_ff;
   logic [4:0]  div_cnt_ff;

   // memories
   logic [FW-1:0] lead_mem [MAX_FRAMES];
   logic [FW-1:0] dub_mem  [MAX_FRAMES];
   logic [23:0]   cost_mem [CD];
   logic [1:0]    dir_mem  [CD];
   logic [EW-1:0] path_mem [PATH_MAX];
   logic [FW-1:0] lead_rd_ff, dub_rd_ff;
   logic [23:0]   diag_rd_ff, up_rd_ff;
   logic [1:0]    dir_rd_ff;
   logic [EW-1:0] path_rd_ff;

   // datapath
   logic [15:0] on_term_ff, pt_term_ff, vc_term_ff;
   logic [33:0] sum_ff;
   logic [18:0] loc_ff;
   logic [23:0] up_cand_ff, left_cand_ff, left_cost_ff, best_ff;
   logic        up_ok_ff, left_ok_ff;
   logic [1:0]  dir_ff;
   logic [PW:0] rem_ff;
   logic [23:0] quo_ff;
   logic [15:0] overall_ff;

   // handshakes and enables
   logic req_acc, rsp_acc, lead_we, dub_we, cost_we, path_we;
   logic [FW-1:0] frame;
   assign req_acc = req_tvalid & req_tready;
   assign rsp_acc = rsp_tvalid & rsp_tready;
   assign frame   = req_tdata[FW-1:0];

   // band bookkeeping
   logic [6:0] band7, cols_m1, nr7, nlo7, nhi7, hi0_7;
   logic [AW-1:0] nlo, nhi, hi0;
   logic [CW-1:0] cnt_gap;
   logic end_in_band, last_row, row_end, origin;
   logic signed [7:0] up_gap, left_gap;

   assign band7   = {2'b00, band_ff};
   assign cols_m1 = 7'(lead_cnt_ff) - 7'd1;
   assign nr7     = 7'(r_ff) + 7'd1;
   assign nlo7    = (nr7 > band7) ? nr7 - band7 : 7'd0;
   assign nhi7    = (nr7 + band7 > cols_m1) ? cols_m1 : nr7 + band7;
   assign hi0_7   = (band7 > cols_m1) ? cols_m1 : band7;
   assign nlo     = nlo7[AW-1:0];
   assign nhi     = nhi7[AW-1:0];
   assign hi0     = hi0_7[AW-1:0];
   assign cnt_gap = (dub_cnt_ff > lead_cnt_ff) ? dub_cnt_ff - lead_cnt_ff
                                               : lead_cnt_ff - dub_cnt_ff;
   assign end_in_band = (dub_cnt_ff != '0) && (lead_cnt_ff != '0) &&
                        (7'(cnt_gap) <= band7);
   assign last_row = (7'(r_ff) == 7'(dub_cnt_ff) - 7'd1);
   assign row_end  = (c_ff == hi_ff);
   assign origin   = (r_ff == '0) && (c_ff == '0);
   assign up_gap   = $signed(8'(c_ff)) - $signed(8'(r_ff)) + 8'sd1;
   assign left_gap = $signed(8'(r_ff)) - $signed(8'(c_ff)) + 8'sd1;

   // local cost terms from the two frames just read
   logic [15:0] on_diff, on_clip, pt_clip;
   logic [18:0] lg_a, lg_b, lg_diff;
   logic        both_pitched;
   assign on_diff = (lead_rd_ff[15:0] > dub_rd_ff[15:0]) ? lead_rd_ff[15:0] - dub_rd_ff[15:0]
                                                       : dub_rd_ff[15:0] - lead_rd_ff[15:0];
   assign on_clip = (on_diff > ONE_Q15) ? ONE_Q15 : on_diff;
   assign lg_a    = log2_q15(lead_rd_ff[32:17]);
   assign lg_b    = log2_q15(dub_rd_ff[32:17]);
   assign lg_diff = (lg_a > lg_b) ? lg_a - lg_b : lg_b - lg_a;
   assign pt_clip = (lg_diff > 19'(ONE_Q15)) ? ONE_Q15 : lg_diff[15:0];
   assign both_pitched = lead_rd_ff[16] && dub_rd_ff[16] &&
                         (lead_rd_ff[32:17] != '0) && (dub_rd_ff[32:17] != '0);

   // one weight multiply per cycle
   logic [15:0] mul_w, mul_t;
   logic [31:0] mul_p;
   always_comb begin
      case (mul_cnt_ff)
         2'd0:    begin mul_w = w_onset_ff; mul_t = on_term_ff; end
         2'd1:    begin mul_w = w_pitch_ff; mul_t = pt_term_ff; end
         2'd2:    begin mul_w = w_voice_ff; mul_t = vc_term_ff; end
         default: begin mul_w = '0;         mul_t = '0;         end
      endcase
   end
   assign mul_p = mul_w * mul_t;

   // choice of predecessor, diagonal first on ties
   logic [23:0] best_sel;
   logic [1:0]  dir_sel;
   always_comb begin
      logic have;
      have     = (r_ff != '0) && (c_ff != '0);
      best_sel = diag_rd_ff;
      dir_sel  = DIR_DIAG;
      if (up_ok_ff && (!have || up_cand_ff < best_sel)) begin
         best_sel = up_cand_ff;
         dir_sel  = DIR_UP;
         have     = 1'b1;
      end
      if (left_ok_ff && (!have || left_cand_ff < best_sel)) begin
         best_sel = left_cand_ff;
         dir_sel  = DIR_LEFT;
      end
      if (origin) best_sel = '0;
   end

   logic [23:0] cost_new;
   logic [PW:0] rem_shift;
   logic [PW-1:0] emit_addr;
   logic        emit_last, trace_done;
   assign cost_new   = sat_add24(best_ff, 24'(loc_ff));
   assign rem_shift  = {rem_ff[PW-1:0], quo_ff[23]};
   assign emit_addr  = n_ff - PW'(1) - k_ff;
   assign emit_last  = (k_ff == n_ff - PW'(1));
   assign trace_done = origin || (n_ff + PW'(1) >= PW'(PATH_MAX));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_acc && req_tuser == MODE_ALIGN)
               state_in = end_in_band ? ST_CELL_RD : ST_FAIL_OUT;
         ST_CELL_RD:   state_in = ST_CELL_TERM;
         ST_CELL_TERM: state_in = ST_CELL_MUL;
         ST_CELL_MUL:  if (mul_cnt_ff == 2'd2) state_in = ST_CELL_SUM;
         ST_CELL_SUM:  state_in = tracing_ff ? ST_TRACE_WR : ST_FILL_WR;
         ST_FILL_WR:   state_in = ST_CELL_RD;
         ST_TRACE_WR:  state_in = trace_done ? ST_DIV : ST_CELL_RD;
         ST_DIV:       if (div_cnt_ff == 5'd23) state_in = ST_EMIT_RD;
         ST_EMIT_RD:   state_in = ST_EMIT_OUT;
         ST_EMIT_OUT:  if (rsp_acc) state_in = emit_last ? ST_IDLE : ST_EMIT_RD;
         ST_FAIL_OUT:  if (rsp_acc) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // handshake, enables and result word
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = 1'b0;
      rsp_tdata  = '0;
      rsp_tuser  = STATUS_OK;
      rsp_tlast  = 1'b0;
      lead_we    = req_acc && req_tuser == MODE_LEAD && lead_cnt_ff < CW'(MAX_FRAMES);
      dub_we     = req_acc && req_tuser == MODE_DUB  && dub_cnt_ff  < CW'(MAX_FRAMES);
      cost_we    = (state_ff == ST_FILL_WR);
      path_we    = (state_ff == ST_TRACE_WR);
      case (state_ff)
         ST_EMIT_OUT: begin
            rsp_tvalid       = 1'b1;
            rsp_tdata[4:0]   = 5'(path_rd_ff[EW-1 -: AW]);
            rsp_tdata[9:5]   = 5'(path_rd_ff[15+AW -: AW]);
            rsp_tdata[25:10] = path_rd_ff[15:0];
            rsp_tdata[41:26] = overall_ff;
            rsp_tuser        = overflow_ff ? STATUS_DROPPED : STATUS_OK;
            rsp_tlast        = emit_last;
         end
         ST_FAIL_OUT: begin
            rsp_tvalid = 1'b1;
            rsp_tuser  = STATUS_NO_PATH;
            rsp_tlast  = 1'b1;
         end
         default: ;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff    <= 5'd8;
         penalty_ff <= 16'd2621;
         w_onset_ff <= 16'd18022;
         w_pitch_ff <= 16'd9830;
         w_voice_ff <= 16'd4915;
      end else if (csr_we) begin
         case (csr_addr)
            REG_BAND:    band_ff    <= csr_wdata[4:0];
            REG_PENALTY: penalty_ff <= csr_wdata;
            REG_W_ONSET: w_onset_ff <= csr_wdata;
            REG_W_PITCH: w_pitch_ff <= csr_wdata;
            REG_W_VOICE: w_voice_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // memories, registered reads
   always_ff @(posedge clock) begin
      if (lead_we) lead_mem[lead_cnt_ff[AW-1:0]] <= frame;
      if (dub_we)  dub_mem[dub_cnt_ff[AW-1:0]]   <= frame;
      lead_rd_ff <= lead_mem[c_ff];
      dub_rd_ff  <= dub_mem[r_ff];
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[{r_ff, c_ff}] <= cost_new;
         dir_mem[{r_ff, c_ff}]  <= dir_ff;
      end
      diag_rd_ff <= cost_mem[{r_ff - AW'(1), c_ff - AW'(1)}];
      up_rd_ff   <= cost_mem[{r_ff - AW'(1), c_ff}];
      dir_rd_ff  <= dir_mem[{r_ff, c_ff}];
   end

   always_ff @(posedge clock) begin
      if (path_we) path_mem[n_ff] <= {r_ff, c_ff, confidence(24'(loc_ff))};
      path_rd_ff <= path_mem[emit_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         lead_cnt_ff <= '0;
         dub_cnt_ff  <= '0;
         overflow_ff <= 1'b0;
         tracing_ff  <= 1'b0;
         r_ff        <= '0;
         c_ff        <= '0;
         hi_ff       <= '0;
         n_ff        <= '0;
         k_ff        <= '0;
         mul_cnt_ff  <= '0;
         div_cnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               if (lead_we) lead_cnt_ff <= lead_cnt_ff + CW'(1);
               if (dub_we)  dub_cnt_ff  <= dub_cnt_ff + CW'(1);
               if (req_acc && (req_tuser == MODE_LEAD || req_tuser == MODE_DUB) &&
                   !lead_we && !dub_we)
                  overflow_ff <= 1'b1;
               r_ff       <= '0;
               c_ff       <= '0;
               hi_ff      <= hi0;
               n_ff       <= '0;
               k_ff       <= '0;
               tracing_ff <= 1'b0;
            end
            ST_CELL_TERM: mul_cnt_ff <= '0;
            ST_CELL_MUL:  mul_cnt_ff <= mul_cnt_ff + 2'd1;
            ST_FILL_WR: begin
               if (row_end) begin
                  if (last_row) begin
                     // band filled, start the traceback at the end cell
                     tracing_ff <= 1'b1;
                     c_ff       <= AW'(cols_m1);
                  end else begin
                     r_ff  <= r_ff + AW'(1);
                     c_ff  <= nlo;
                     hi_ff <= nhi;
                  end
               end else begin
                  c_ff <= c_ff + AW'(1);
               end
            end
            ST_TRACE_WR: begin
               n_ff       <= n_ff + PW'(1);
               div_cnt_ff <= '0;
               if (!trace_done) begin
                  case (dir_rd_ff)
                     DIR_DIAG: begin r_ff <= r_ff - AW'(1); c_ff <= c_ff - AW'(1); end
                     DIR_UP:   r_ff <= r_ff - AW'(1);
                     default:  c_ff <= c_ff - AW'(1);
                  endcase
               end
            end
            ST_DIV:      div_cnt_ff <= div_cnt_ff + 5'd1;
            ST_EMIT_OUT: begin
               if (rsp_acc) begin
                  k_ff <= k_ff + PW'(1);
                  if (emit_last) begin
                     lead_cnt_ff <= '0;
                     dub_cnt_ff  <= '0;
                     overflow_ff <= 1'b0;
                  end
               end
            end
            ST_FAIL_OUT: begin
               if (rsp_acc) begin
                  lead_cnt_ff <= '0;
                  dub_cnt_ff  <= '0;
                  overflow_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_CELL_TERM: begin
            on_term_ff   <= on_clip;
            pt_term_ff   <= both_pitched ? pt_clip : 16'd0;
            vc_term_ff   <= (lead_rd_ff[16] != dub_rd_ff[16]) ? ONE_Q15 : 16'd0;
            sum_ff       <= '0;
            up_cand_ff   <= sat_add24(up_rd_ff, 24'(penalty_ff));
            left_cand_ff <= sat_add24(left_cost_ff, 24'(penalty_ff));
            up_ok_ff     <= (r_ff != '0) && (up_gap <= $signed({3'b000, band_ff}));
            left_ok_ff   <= (c_ff != '0) && (left_gap <= $signed({3'b000, band_ff}));
         end
         ST_CELL_MUL: sum_ff <= sum_ff + 34'(mul_p);
         ST_CELL_SUM: begin
            loc_ff  <= 19'((sum_ff + 34'd16384) >> 15);
            best_ff <= best_sel;
            dir_ff  <= dir_sel;
         end
         ST_FILL_WR: left_cost_ff <= cost_new;
         ST_TRACE_WR: begin
            // end cell cost over the path length
            rem_ff <= '0;
            quo_ff <= left_cost_ff;
         end
         ST_DIV: begin
            if (rem_shift >= (PW+1)'(n_ff)) begin
               rem_ff <= rem_shift - (PW+1)'(n_ff);
               quo_ff <= {quo_ff[22:0], 1'b1};
            end else begin
               rem_ff <= rem_shift;
               quo_ff <= {quo_ff[22:0], 1'b0};
            end
         end
         ST_EMIT_RD: overall_ff <= confidence(quo_ff);
         default: ;
      endcase
   end

`include "banded_dtw_frame_aligner_core_assert.svh"

   // a single run at a time: no new word while a result is offered
   `BDFA_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_tvalid, !req_tready, "input in output")
   // mean divider always sees at least one path point
   `BDFA_ASSERT_IMPL(a_div_nonzero, clock, reset, state_ff == ST_DIV, n_ff != '0, "empty path")
   // the last result of a run clears the frame counts
   `BDFA_ASSERT_NEXT(a_clear_after, clock, reset, rsp_acc && rsp_tlast,
      lead_cnt_ff == '0 && dub_cnt_ff == '0 && !overflow_ff, "counts not cleared")

endmodule

@@ dv/bdfa_path_checker.sv @@
// ----------------------------------------------------------------------------
// bdfa_path_checker
// watches the frame, csr and path channels of the aligner, predicts each
// alignment run in banded dtw terms and compares the path words one by one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdfa_path_checker #(
   parameter int MAX_FRAMES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import bdfa_pkg::*;

   typedef struct packed {
      logic [15:0] pitch;
      logic        voiced;
      logic [15:0] onset;
   } frame_type;

   typedef struct {
      logic [4:0]  dub;
      logic [4:0]  lead;
      logic [15:0] point_conf;
      logic [15:0] overall;
      logic [1:0]  status;
      logic        last;
   } path_word_type;

   localparam int unsigned Q_ONE   = 32768;
   localparam int unsigned SAT_MAX = 24'hFFFFFF;

   // log2(1 + i/32) in q0.15
   localparam int unsigned FRAC_LUT [32] = '{
      0, 1455, 2866, 4236, 5568, 6863, 8124, 9352,
      10549, 11716, 12855, 13968, 15055, 16117, 17156, 18173,
      19168, 20143, 21098, 22034, 22952, 23853, 24736, 25604,
      26455, 27292, 28114, 28922, 29717, 30498, 31267, 32024};

   frame_type     lead_q [MAX_FRAMES];
   frame_type     dub_q  [MAX_FRAMES];
   int unsigned   n_lead, n_dub;
   bit            dropped;
   int unsigned   band, penalty, w_onset, w_pitch, w_voice;
   path_word_type path_q [$];

   int unsigned acc_cost [MAX_FRAMES][MAX_FRAMES];
   bit          reached  [MAX_FRAMES][MAX_FRAMES];
   logic [1:0]  came_from[MAX_FRAMES][MAX_FRAMES];

   function automatic int unsigned pitch_log2(input logic [15:0] p);
      int unsigned msb;
      logic [15:0] norm;
      msb = 0;
      for (int i = 0; i < 16; i++) if (p[i]) msb = i;
      norm = p << (15 - msb);
      return msb * Q_ONE + FRAC_LUT[norm[14:10]];
   endfunction

   function automatic int unsigned frame_cost(input frame_type lf, input frame_type df);
      int unsigned d_on, d_pt, d_vc, a, b;
      longint unsigned acc;
      d_on = (lf.onset > df.onset) ? lf.onset - df.onset : df.onset - lf.onset;
      if (d_on > Q_ONE) d_on = Q_ONE;
      d_vc = (lf.voiced != df.voiced) ? Q_ONE : 0;
      d_pt = 0;
      // pitch counts only when both sides are voiced with a pitch
      if (lf.voiced && df.voiced && lf.pitch != 0 && df.pitch != 0) begin
         a = pitch_log2(lf.pitch);
         b = pitch_log2(df.pitch);
         d_pt = (a > b) ? a - b : b - a;
         if (d_pt > Q_ONE) d_pt = Q_ONE;
      end
      acc = longint'(w_onset) * d_on + longint'(w_pitch) * d_pt + longint'(w_voice) * d_vc;
      return int'((acc + 16384) >> 15);
   endfunction

   function automatic int unsigned add_sat(input int unsigned a, input int unsigned b);
      return (a + b > SAT_MAX) ? SAT_MAX : a + b;
   endfunction

   function automatic logic [15:0] to_conf(input int unsigned c);
      return 16'(Q_ONE - ((c > Q_ONE) ? Q_ONE : c));
   endfunction

   task automatic expect_no_path();
      path_word_type w;
      w = '{dub: 0, lead: 0, point_conf: 0, overall: 0, status: STATUS_NO_PATH, last: 1};
      path_q.insert(path_q.size(), w);
   endtask

   // fills the band, traces back from the end cell and queues the path words
   task automatic predict_alignment();
      int unsigned   lo, hi, loc, best, cand, r, c, n;
      logic [1:0]    dir;
      bit            have;
      path_word_type trail [$];
      path_word_type w;
      logic [15:0]   overall;
      if (n_lead == 0 || n_dub == 0) begin
         expect_no_path();
         return;
      end
      foreach (reached[i, j]) reached[i][j] = 0;
      for (int rr = 0; rr < n_dub; rr++) begin
         lo = (rr > band) ? rr - band : 0;
         hi = (rr + band > n_lead - 1) ? n_lead - 1 : rr + band;
         for (int cc = lo; cc <= hi; cc++) begin
            loc = frame_cost(lead_q[cc], dub_q[rr]);
            if (rr == 0 && cc == 0) begin
               acc_cost[0][0] = (loc > SAT_MAX) ? SAT_MAX : loc;
               reached[0][0] = 1;
               continue;
            end
            have = 0;
            best = 0;
            dir  = DIR_DIAG;
            // ties keep diagonal, then vertical, then horizontal
            if (rr > 0 && cc > 0 && reached[rr-1][cc-1]) begin
               best = acc_cost[rr-1][cc-1];
               dir  = DIR_DIAG;
               have = 1;
            end
            if (rr > 0 && reached[rr-1][cc]) begin
               cand = add_sat(acc_cost[rr-1][cc], penalty);
               if (!have || cand < best) begin
                  best = cand; dir = DIR_UP; have = 1;
               end
            end
            if (cc > 0 && reached[rr][cc-1]) begin
               cand = add_sat(acc_cost[rr][cc-1], penalty);
               if (!have || cand < best) begin
                  best = cand; dir = DIR_LEFT; have = 1;
               end
            end
            if (have) begin
               acc_cost[rr][cc]  = add_sat(best, loc);
               came_from[rr][cc] = dir;
               reached[rr][cc]   = 1;
            end
         end
      end
      if (!reached[n_dub-1][n_lead-1]) begin
         expect_no_path();
         return;
      end
      r = n_dub - 1;
      c = n_lead - 1;
      n = 0;
      forever begin
         if (n >= 2 * MAX_FRAMES - 1) break;
         w.dub        = 5'(r);
         w.lead       = 5'(c);
         w.point_conf = to_conf(frame_cost(lead_q[c], dub_q[r]));
         trail.push_front(w);
         n++;
         if (r == 0 && c == 0) break;
         case (came_from[r][c])
            DIR_DIAG: begin r--; c--; end
            DIR_UP:   r--;
            default:  c--;
         endcase
      end
      overall = to_conf(acc_cost[n_dub-1][n_lead-1] / n);
      foreach (trail[k]) begin
         w         = trail[k];
         w.overall = overall;
         w.status  = dropped ? STATUS_DROPPED : STATUS_OK;
         w.last    = (k == trail.size() - 1);
         path_q.insert(path_q.size(), w);
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] path word mismatch on %s: got %0d, want %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      path_word_type want;
      frame_type     f;
      if (reset) begin
         n_lead = 0; n_dub = 0; dropped = 0;
         band = 8; penalty = 2621; w_onset = 18022; w_pitch = 9830; w_voice = 4915;
         path_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (path_q.size() == 0) begin
               report_mismatch("words pending", 0, 1);
            end else begin
               want = path_q.pop_front();
               if (rsp_tdata[4:0] !== want.dub)
                  report_mismatch("dub index", rsp_tdata[4:0], want.dub);
               if (rsp_tdata[9:5] !== want.lead)
                  report_mismatch("lead index", rsp_tdata[9:5], want.lead);
               if (rsp_tdata[25:10] !== want.point_conf)
                  report_mismatch("point conf", rsp_tdata[25:10], want.point_conf);
               if (rsp_tdata[41:26] !== want.overall)
                  report_mismatch("overall conf", rsp_tdata[41:26], want.overall);
               if (rsp_tuser !== want.status)
                  report_mismatch("status", rsp_tuser, want.status);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", rsp_tlast, want.last);
            end
         end
         if (csr_we) begin
            case (csr_addr)
               REG_BAND:    band    = csr_wdata[4:0];
               REG_PENALTY: penalty = csr_wdata;
               REG_W_ONSET: w_onset = csr_wdata;
               REG_W_PITCH: w_pitch = csr_wdata;
               REG_W_VOICE: w_voice = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            f = req_tdata[32:0];
            case (req_tuser)
               MODE_LEAD: begin
                  if (n_lead < MAX_FRAMES) begin
                     lead_q[n_lead] = f;
                     n_lead++;
                  end else begin
                     dropped = 1;
                  end
               end
               MODE_DUB: begin
                  if (n_dub < MAX_FRAMES) begin
                     dub_q[n_dub] = f;
                     n_dub++;
                  end else begin
                     dropped = 1;
                  end
               end
               MODE_ALIGN: begin
                  predict_alignment();
                  n_lead = 0; n_dub = 0; dropped = 0;
               end
               default: ;
            endcase
         end
      end
      pending = path_q.size();
   end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives frame loads, align words and register settings into the dtw aligner;
// a side checker predicts every path word and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import bdfa_pkg::*;

   localparam int FRAMES     = 32;
   localparam int WORD_GOAL  = 460;
   localparam int STALL_MAX  = 60000;   // covers the silence of a full 32x32 band
   localparam logic [1:0] MODE_SPARE = 2'd3;   // unused mode, ignored by the block

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // onset[15:0], voiced[16], pitch[32:17], zero pad
   logic [1:0]  req_tuser;    // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // dub[4:0], lead[9:5], point conf[25:10], overall[41:26]
   logic [1:0]  rsp_tuser;    // status[1:0]
   logic        rsp_tlast;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [15:0] csr_wdata;

   int  fail_count;
   int  pending;
   int  words_sent;
   int  quiet_cycles;
   bit  gaps_on;              // random idling on both channels

   logic [32:0] lead_set [FRAMES+2];

   banded_dtw_frame_aligner_core #(.MAX_FRAMES(FRAMES)) u_top (.*);

   bdfa_path_checker #(.MAX_FRAMES(FRAMES)) u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_we, .csr_addr, .csr_wdata, .fail_count, .pending
   );

   initial clock = 0;
   always #6 clock = ~clock;

   // receiver back-pressure, ready is low about 18 percent of the time while gaps are on
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= gaps_on ? ($urandom_range(99) >= 18) : 1'b1;
   end

   // no word moving on either side for too long means the block hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_MAX) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // one word on the frame channel; valid stays high into the next word
   task automatic push_word(input logic [1:0] mode, input logic [32:0] frame);
      bit taken;
      while (gaps_on && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, frame};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      words_sent++;
   endtask

   // wait for every path word, then let the block settle back to idle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      wait (pending == 0);
      @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // register writes back to back, only while drained
   task automatic program_regs(input int b, input int pen, input int wo, input int wp,
                               input int wv);
      logic [15:0] vals [5];
      vals = '{16'(b), 16'(pen), 16'(wo), 16'(wp), 16'(wv)};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [32:0] make_frame();
      logic [15:0] onset, pitch;
      case ($urandom_range(5))
         0:       onset = 16'h0000;
         1:       onset = 16'hFFFF;
         default: onset = 16'($urandom);
      endcase
      case ($urandom_range(5))
         0:       pitch = 16'h0000;
         1:       pitch = 16'($urandom_range(1, 63));
         2:       pitch = 16'hFFFF;
         default: pitch = 16'($urandom);
      endcase
      return {pitch, 1'($urandom), onset};
   endfunction

   // dub frame close to a lead frame so the path follows real structure
   function automatic logic [32:0] near_copy(input logic [32:0] f);
      logic [15:0] onset;
      onset = f[15:0] ^ 16'($urandom_range(0, 1023));
      return {f[32:17] + 16'($urandom_range(0, 8)), f[16], onset};
   endfunction

   // one alignment run with frames in random order, then the align word
   task automatic run_alignment(input int nl, input int nd);
      int li, di;
      for (int i = 0; i < nl; i++) lead_set[i] = make_frame();
      li = 0;
      di = 0;
      while (li < nl || di < nd) begin
         if (di >= nd || (li < nl && $urandom_range(1))) begin
            push_word(MODE_LEAD, lead_set[li]);
            li++;
         end else begin
            if (nl > 0 && $urandom_range(3) != 0)
               push_word(MODE_DUB, near_copy(lead_set[(di < nl) ? di : nl - 1]));
            else
               push_word(MODE_DUB, make_frame());
            di++;
         end
         if ($urandom_range(49) == 0) push_word(MODE_SPARE, make_frame());
      end
      push_word(MODE_ALIGN, 33'($urandom));
   endtask

   task automatic random_runs(input int goal);
      int nl, nd;
      while (words_sent < goal) begin
         case ($urandom_range(19))
            0:       begin nl = 0; nd = $urandom_range(0, 3); end
            1:       begin nl = $urandom_range(1, 6); nd = $urandom_range(10, 20); end
            default: begin nl = $urandom_range(1, 8); nd = nl + $urandom_range(0, 4) - 2; end
         endcase
         if (nd < 0) nd = 0;
         run_alignment(nl, nd);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_LEAD;
      csr_we     = 1'b0;
      csr_addr   = REG_BAND;
      csr_wdata  = '0;
      gaps_on    = 1'b1;
      words_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty input, ignored mode, field extremes, lone side, band miss
      push_word(MODE_ALIGN, '0);
      push_word(MODE_SPARE, {16'hFFFF, 1'b1, 16'hFFFF});
      push_word(MODE_LEAD, {16'hFFFF, 1'b1, 16'h0000});
      push_word(MODE_LEAD, {16'h0001, 1'b1, 16'hFFFF});
      push_word(MODE_DUB, {16'h0010, 1'b1, 16'hFFFF});
      push_word(MODE_DUB, {16'h0000, 1'b0, 16'h0000});
      push_word(MODE_ALIGN, '0);
      push_word(MODE_LEAD, {16'h8000, 1'b1, 16'h8000});
      push_word(MODE_ALIGN, '0);
      push_word(MODE_LEAD, {16'h0100, 1'b1, 16'h1234});
      for (int i = 0; i < 10; i++) push_word(MODE_DUB, make_frame());
      push_word(MODE_ALIGN, '0);   // end cell nine rows off a band of eight

      // phases of settings, the sender waits for the path before each write
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            0: program_regs(0, 0, 32768, 32768, 32768);
            1: program_regs(31, 32768, 0, 0, 0);
            2: program_regs(31, 2621, 18022, 9830, 4915);
            3: program_regs(1, 65535, 65535, 65535, 65535);
            default: program_regs($urandom_range(31), $urandom_range(32768),
                                  $urandom_range(32768), $urandom_range(32768),
                                  $urandom_range(32768));
         endcase
         if (phase == 2) begin
            // long stretch with no idling, full band and dropped frames
            gaps_on = 1'b0;
            run_alignment(FRAMES, FRAMES);
            run_alignment(FRAMES + 2, FRAMES + 1);
         end
         random_runs(40 + (phase + 1) * (WORD_GOAL - 40) / 8);
         gaps_on = 1'b1;
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
